FILE: sv/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property that is ignored while reset is high.
`define RRR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ray reflect/refract assertion failed");

// Checked property that also holds across reset.
`define RRR_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("ray reflect/refract assertion failed");

`endif

FILE: sv/rrr_pkg.sv
package rrr_pkg;

   // Function select codes.
   localparam logic FUNC_REFLECT = 1'b0;
   localparam logic FUNC_REFRACT = 1'b1;

   localparam int SQRT_STAGES = 16;
   localparam int SQRT_TOP    = 62;

   typedef logic signed [67:0] wide_type;
   typedef logic [2:0][31:0]   vec_type;

   localparam wide_type MAX32 = 68'sd2147483647;
   localparam wide_type MIN32 = -68'sd2147483648;
   localparam logic signed [32:0] ONE_Q16 = 33'sd65536;

   typedef struct packed {
      logic              func;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
      logic signed [31:0] norm_x;
      logic signed [31:0] norm_y;
      logic signed [31:0] norm_z;
      logic [23:0]        eta_ratio;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
   } rsp_type;

   // Values that ride alongside the square root.
   typedef struct packed {
      logic    func;
      vec_type n;
      vec_type r;
      vec_type p;
   } side_type;

   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] res;
   } sq_type;

   // Clamp a wide signed value to the 32 bit range.
   function automatic logic [31:0] sat32(input wide_type v);
      if (v > MAX32) begin
         return 32'h7FFF_FFFF;
      end else if (v < MIN32) begin
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   // One digit of the restoring square root.
   function automatic sq_type sqrt_step(input sq_type s, input logic [63:0] bitv);
      logic [64:0] trial;
      sq_type      o;
      trial = {1'b0, s.res} + {1'b0, bitv};
      if ({1'b0, s.rem} >= trial) begin
         o.rem = s.rem - trial[63:0];
         o.res = (s.res >> 1) + bitv;
      end else begin
         o.rem = s.rem;
         o.res = s.res >> 1;
      end
      return o;
   endfunction

endpackage

FILE: sv/ray_reflect_refract.sv
// Channel   | Ports                          | Carries
// request   | req_valid, req_ready, req_data | func, dir, norm, eta_ratio
// response  | rsp_valid, rsp_ready, rsp_data | out_x, out_y, out_z
//
// One request enters per cycle unless a stalled response holds the pipeline.
// The depth is set by the square root, two result bits per stage over 16 stages.
// Reset clears only the valid bits; there is no stored state between requests.
// A stalled response freezes the whole pipeline, so req_ready drops with it.
`include "assert_macros.svh"

module ray_reflect_refract (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rrr_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rrr_pkg::rsp_type  rsp_data
);

   logic              en;
   logic              f_vld;
   rrr_pkg::side_type f_side;
   logic              m_vld;
   logic [63:0]       m_rem;
   rrr_pkg::side_type m_side;
   logic              s_vld;
   logic [31:0]       s_root;
   rrr_pkg::side_type s_side;

   // The pipeline moves whenever the output slot is free or being emptied.
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   rrr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (req_valid),
      .in_req   (req_data),
      .out_vld  (f_vld),
      .out_side (f_side)
   );

   rrr_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (f_vld),
      .in_side  (f_side),
      .out_vld  (m_vld),
      .out_rem  (m_rem),
      .out_side (m_side)
   );

   rrr_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (m_vld),
      .in_rem   (m_rem),
      .in_side  (m_side),
      .out_vld  (s_vld),
      .out_root (s_root),
      .out_side (s_side)
   );

   rrr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s_vld),
      .in_root  (s_root),
      .in_side  (s_side),
      .out_vld  (rsp_valid),
      .out_rsp  (rsp_data)
   );

   // A response held back blocks new requests.
   `RRR_ASSERT(a_stall_blocks, clock, reset, (rsp_valid && !rsp_ready) |-> !req_ready)
   // No response can be pending right after reset.
   `RRR_ASSERT_ALWAYS(a_reset_clears, clock, $past(reset) |-> !rsp_valid)
   // A valid square-root stage output is never lost while stalled.
   `RRR_ASSERT(a_sqrt_hold, clock, reset, (s_vld && !en) |=> s_vld)

endmodule

FILE: sv/rrr_front.sv
module rrr_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_vld,
   input  rrr_pkg::req_type   in_req,
   output logic               out_vld,
   output rrr_pkg::side_type  out_side
);

   logic [5:0] vld_ff;
   logic [5:0] vld_in;

   logic               func_ff [6];
   rrr_pkg::vec_type   d_ff [3];
   rrr_pkg::vec_type   n_ff [6];
   logic [23:0]        eta_ff [4];

   logic signed [63:0] dp_ff [3];
   logic signed [31:0] g_ff;
   logic signed [63:0] rp_ff [3];
   logic signed [63:0] cp_ff [3];
   rrr_pkg::vec_type   r_ff [3];
   rrr_pkg::vec_type   t_ff;
   logic signed [63:0] ep_ff [3];
   rrr_pkg::vec_type   p_ff;

   rrr_pkg::vec_type        din;
   rrr_pkg::vec_type        nin;
   rrr_pkg::wide_type       dsum;
   logic signed [32:0]      negg;
   logic signed [31:0]      cval;

   assign din = {in_req.dir_z, in_req.dir_y, in_req.dir_x};
   assign nin = {in_req.norm_z, in_req.norm_y, in_req.norm_x};
   assign vld_in = {vld_ff[4:0], in_vld};

   // Valid bits advance with the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Exact dot product and the clamped cosine.
   always_comb begin
      dsum = rrr_pkg::wide_type'(dp_ff[0]) + rrr_pkg::wide_type'(dp_ff[1])
           + rrr_pkg::wide_type'(dp_ff[2]);
      negg = -(33'($signed(g_ff)));
      cval = (negg > rrr_pkg::ONE_Q16) ? 32'sd65536 : negg[31:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // Stage 1: component products of d and n.
         func_ff[0] <= in_req.func;
         d_ff[0]    <= din;
         n_ff[0]    <= nin;
         eta_ff[0]  <= in_req.eta_ratio;
         for (int i = 0; i < 3; i++) begin
            dp_ff[i] <= $signed(din[i]) * $signed(nin[i]);
         end

         // Stage 2: saturated dot product.
         func_ff[1] <= func_ff[0];
         d_ff[1]    <= d_ff[0];
         n_ff[1]    <= n_ff[0];
         eta_ff[1]  <= eta_ff[0];
         g_ff       <= rrr_pkg::sat32(dsum >>> 16);

         // Stage 3: g*n for reflect, c*n for refract.
         func_ff[2] <= func_ff[1];
         d_ff[2]    <= d_ff[1];
         n_ff[2]    <= n_ff[1];
         eta_ff[2]  <= eta_ff[1];
         for (int i = 0; i < 3; i++) begin
            rp_ff[i] <= g_ff * $signed(n_ff[1][i]);
            cp_ff[i] <= cval * $signed(n_ff[1][i]);
         end

         // Stage 4: reflected vector and the refract sum d + c*n.
         func_ff[3] <= func_ff[2];
         n_ff[3]    <= n_ff[2];
         eta_ff[3]  <= eta_ff[2];
         for (int i = 0; i < 3; i++) begin
            r_ff[0][i] <= rrr_pkg::sat32(rrr_pkg::wide_type'($signed(d_ff[2][i]))
                          - (rrr_pkg::wide_type'(rp_ff[i]) >>> 15));
            t_ff[i]    <= rrr_pkg::sat32(rrr_pkg::wide_type'($signed(d_ff[2][i]))
                          + (rrr_pkg::wide_type'(cp_ff[i]) >>> 16));
         end

         // Stage 5: scale by eta.
         func_ff[4] <= func_ff[3];
         n_ff[4]    <= n_ff[3];
         r_ff[1]    <= r_ff[0];
         for (int i = 0; i < 3; i++) begin
            ep_ff[i] <= $signed({8'd0, eta_ff[3]}) * $signed(t_ff[i]);
         end

         // Stage 6: perpendicular part.
         func_ff[5] <= func_ff[4];
         n_ff[5]    <= n_ff[4];
         r_ff[2]    <= r_ff[1];
         for (int i = 0; i < 3; i++) begin
            p_ff[i] <= rrr_pkg::sat32(rrr_pkg::wide_type'(ep_ff[i]) >>> 16);
         end
      end
   end

   assign out_vld       = vld_ff[5];
   assign out_side.func = func_ff[5];
   assign out_side.n    = n_ff[5];
   assign out_side.r    = r_ff[2];
   assign out_side.p    = p_ff;

endmodule

FILE: sv/rrr_norm.sv
module rrr_norm (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_vld,
   input  rrr_pkg::side_type  in_side,
   output logic               out_vld,
   output logic [63:0]        out_rem,
   output rrr_pkg::side_type  out_side
);

   logic [1:0]          vld_ff;
   logic signed [63:0]  pp_ff [3];
   rrr_pkg::side_type   side_ff [2];
   logic [63:0]         rem_ff;

   rrr_pkg::wide_type   psum;
   rrr_pkg::wide_type   diff;
   rrr_pkg::wide_type   mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[0], in_vld};
      end
   end

   // Squared length of p, then |1 - L| placed under 16 fraction bits.
   always_comb begin
      psum = rrr_pkg::wide_type'(pp_ff[0]) + rrr_pkg::wide_type'(pp_ff[1])
           + rrr_pkg::wide_type'(pp_ff[2]);
      diff = rrr_pkg::wide_type'(rrr_pkg::ONE_Q16) - (psum >>> 16);
      mag  = diff[67] ? -diff : diff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int i = 0; i < 3; i++) begin
            pp_ff[i] <= $signed(in_side.p[i]) * $signed(in_side.p[i]);
         end
         side_ff[1] <= side_ff[0];
         rem_ff     <= {mag[47:0], 16'd0};
      end
   end

   assign out_vld  = vld_ff[1];
   assign out_rem  = rem_ff;
   assign out_side = side_ff[1];

endmodule

FILE: sv/rrr_sqrt.sv
module rrr_sqrt (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_vld,
   input  logic [63:0]        in_rem,
   input  rrr_pkg::side_type  in_side,
   output logic               out_vld,
   output logic [31:0]        out_root,
   output rrr_pkg::side_type  out_side
);

   localparam int N = rrr_pkg::SQRT_STAGES;

   logic [N-1:0]       vld_ff;
   rrr_pkg::sq_type    sq_ff [N];
   rrr_pkg::side_type  side_ff [N];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[N-2:0], in_vld};
      end
   end

   // Two result bits per stage, from the top digit down.
   for (genvar j = 0; j < N; j++) begin : g_stage
      localparam logic [63:0] BIT_A = 64'd1 << (rrr_pkg::SQRT_TOP - 4 * j);
      localparam logic [63:0] BIT_B = 64'd1 << (rrr_pkg::SQRT_TOP - 4 * j - 2);
      rrr_pkg::sq_type src;
      rrr_pkg::sq_type mid;
      rrr_pkg::side_type sd;

      if (j == 0) begin : g_first
         assign src = '{rem: in_rem, res: 64'd0};
         assign sd  = in_side;
      end else begin : g_next
         assign src = sq_ff[j-1];
         assign sd  = side_ff[j-1];
      end

      assign mid = rrr_pkg::sqrt_step(src, BIT_A);

      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[j]   <= rrr_pkg::sqrt_step(mid, BIT_B);
            side_ff[j] <= sd;
         end
      end
   end

   assign out_vld  = vld_ff[N-1];
   assign out_root = sq_ff[N-1].res[31:0];
   assign out_side = side_ff[N-1];

endmodule

FILE: sv/rrr_back.sv
module rrr_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_vld,
   input  logic [31:0]        in_root,
   input  rrr_pkg::side_type  in_side,
   output logic               out_vld,
   output rrr_pkg::rsp_type   out_rsp
);

   logic               vld_ff;
   logic               res_vld_ff;
   logic signed [63:0] qp_ff [3];
   rrr_pkg::side_type  side_ff;
   rrr_pkg::vec_type   res_ff;

   logic [30:0] q;

   assign q = in_root[31] ? 31'h7FFF_FFFF : in_root[30:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= 1'b0;
         res_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= in_vld;
         res_vld_ff <= vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // Parallel part: q times the normal.
         side_ff <= in_side;
         for (int i = 0; i < 3; i++) begin
            qp_ff[i] <= $signed({1'b0, q}) * $signed(in_side.n[i]);
         end
         // Select the function result; refract adds p and -q*n.
         for (int i = 0; i < 3; i++) begin
            if (side_ff.func == rrr_pkg::FUNC_REFRACT) begin
               res_ff[i] <= rrr_pkg::sat32(rrr_pkg::wide_type'($signed(side_ff.p[i]))
                            + ((-rrr_pkg::wide_type'(qp_ff[i])) >>> 16));
            end else begin
               res_ff[i] <= side_ff.r[i];
            end
         end
      end
   end

   assign out_vld       = res_vld_ff;
   assign out_rsp.out_x = res_ff[0];
   assign out_rsp.out_y = res_ff[1];
   assign out_rsp.out_z = res_ff[2];

endmodule

FILE: tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY     = 26;
   localparam int NUM_RANDOM  = 530;
   localparam int IDLE_LIMIT  = 5000;
   localparam int LONG_HOLD   = 400;

   // Golden model of the reflect/refract datapath, written with wide integers.
   class ray_scoreboard;
      rrr_pkg::rsp_type expected_dirs[$];
      int      mismatches;
      int      checked;

      function longint floor_div(longint v, int k);
         return v >>> k;
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
         end
         if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
         end
         return v;
      endfunction

      // Exact floor((a.b) / 2^16): products can reach 2^62 each, so sum in 68 bits.
      function longint dot_q16(longint a[3], longint b[3]);
         logic signed [67:0] acc;
         acc = 0;
         for (int i = 0; i < 3; i++) begin
            acc += 68'(a[i]) * 68'(b[i]);
         end
         acc = acc >>> 16;
         if (acc > 68'sd4611686018427387903) begin
            return 64'sd4611686018427387903;
         end
         return longint'(acc);
      endfunction

      function longint int_sqrt(logic [63:0] v);
         logic [63:0] res;
         logic [63:0] bitv;
         res  = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) begin
            bitv = bitv >> 2;
         end
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v   = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return longint'(res);
      endfunction

      function rrr_pkg::rsp_type trace_ray(rrr_pkg::req_type rq);
         longint  d[3];
         longint  n[3];
         longint  p[3];
         longint  r[3];
         longint  g;
         longint  c;
         longint  eta;
         longint  len;
         longint  a;
         longint  q;
         rrr_pkg::rsp_type rs;
         d[0] = rq.dir_x;  d[1] = rq.dir_y;  d[2] = rq.dir_z;
         n[0] = rq.norm_x; n[1] = rq.norm_y; n[2] = rq.norm_z;
         eta  = longint'({40'd0, rq.eta_ratio});
         g    = clamp32(dot_q16(d, n));
         if (rq.func == rrr_pkg::FUNC_REFLECT) begin
            for (int i = 0; i < 3; i++) begin
               r[i] = clamp32(d[i] - floor_div(g * n[i], 15));
            end
         end else begin
            c = -g;
            if (c > 65536) begin
               c = 65536;
            end
            for (int i = 0; i < 3; i++) begin
               p[i] = clamp32(floor_div(eta * clamp32(d[i] + floor_div(c * n[i], 16)), 16));
            end
            len = dot_q16(p, p);
            a   = 65536 - len;
            if (a < 0) begin
               a = -a;
            end
            q = int_sqrt(64'(a) << 16);
            if (q > 64'sd2147483647) begin
               q = 64'sd2147483647;
            end
            for (int i = 0; i < 3; i++) begin
               r[i] = clamp32(p[i] + floor_div(-q * n[i], 16));
            end
         end
         rs.out_x = r[0][31:0];
         rs.out_y = r[1][31:0];
         rs.out_z = r[2][31:0];
         return rs;
      endfunction

      function void note_request(rrr_pkg::req_type rq);
         expected_dirs.push_back(trace_ray(rq));
      endfunction

      function void check_response(rrr_pkg::rsp_type got);
         rrr_pkg::rsp_type exp_dir;
         if (expected_dirs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Unexpected response %h with nothing pending", got);
            end
            return;
         end
         exp_dir = expected_dirs.pop_front();
         checked++;
         if (got.out_x !== exp_dir.out_x || got.out_y !== exp_dir.out_y ||
             got.out_z !== exp_dir.out_z) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Direction mismatch: expected (%0d, %0d, %0d) got (%0d, %0d, %0d)",
                        exp_dir.out_x, exp_dir.out_y, exp_dir.out_z,
                        got.out_x, got.out_y, got.out_z);
            end
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   rrr_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rrr_pkg::rsp_type rsp_data;

   ray_scoreboard dir_board = new();
   rrr_pkg::req_type directed_rays[$];
   bit            hold_active = 1'b0;
   int            idle_cycles = 0;
   int            reflect_count = 0;
   int            refract_count = 0;

   always #10 clock = ~clock;

   ray_reflect_refract DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Record accepted requests and check accepted responses at each edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            dir_board.note_request(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            dir_board.check_response(rsp_data);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // The run ends early if nothing moves for too long.
   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog expired with %0d results pending", dir_board.expected_dirs.size());
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 131072)) - 65536);
         2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
         3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      endcase
   endfunction

   function automatic rrr_pkg::req_type rand_ray();
      rrr_pkg::req_type rq;
      rq.func   = $urandom_range(0, 1) ? rrr_pkg::FUNC_REFRACT : rrr_pkg::FUNC_REFLECT;
      rq.dir_x  = rand_coord();
      rq.dir_y  = rand_coord();
      rq.dir_z  = rand_coord();
      rq.norm_x = rand_coord();
      rq.norm_y = rand_coord();
      rq.norm_z = rand_coord();
      case ($urandom_range(0, 3))
         0: rq.eta_ratio = 24'($urandom());
         1: rq.eta_ratio = 24'($urandom_range(0, 1) ? 24'hFFFFFF : 24'h0);
         default: rq.eta_ratio = 24'($urandom_range(32768, 131072));
      endcase
      return rq;
   endfunction

   function automatic rrr_pkg::req_type make_ray(logic f, logic [31:0] dx, logic [31:0] dy,
                                                 logic [31:0] dz, logic [31:0] nx,
                                                 logic [31:0] ny, logic [31:0] nz,
                                                 logic [23:0] eta);
      rrr_pkg::req_type rq;
      rq = '{f, dx, dy, dz, nx, ny, nz, eta};
      return rq;
   endfunction

   // Offer one request after a random gap and wait for its acceptance.
   task automatic send_ray(rrr_pkg::req_type rq);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 4) == 0) begin
         gap = 0;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      if (rq.func == rrr_pkg::FUNC_REFLECT) begin
         reflect_count++;
      end else begin
         refract_count++;
      end
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   // Receiver: random stalls, plus one long hold while requests keep coming.
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_active) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_active = 1'b0;
         end
         stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) begin
            @(posedge clock);
         end
      end
   end

   // Main sequence: reset, directed rays, random rays, then drain.
   initial begin
      int wait_cycles;
      localparam logic [31:0] ONE  = 32'h0001_0000;
      localparam logic [31:0] MONE = 32'hFFFF_0000;
      localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
      localparam logic [31:0] NMIN = 32'h8000_0000;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: head-on hits, grazing, unnormalized, extremes, eta corners.
      directed_rays.push_back(make_ray(rrr_pkg::FUNC_REFLECT, 0, 0, MONE, 0, 0, ONE,
                                       24'h010000));
      directed_rays.push_back(make_ray(rrr_pkg::FUNC_REFRACT, 0, 0, MONE, 0, 0, ONE,
                                       24'h010000));
      directed_rays.push_back(make_ray(rrr_pkg::FUNC_REFRACT, 0, 0, MONE, 0, 0, ONE,
                                       24'h00AAAA));
      directed_rays.push_back(make_ray(rrr_pkg::FUNC_REFRACT, 32'h0000_B504, 0,
                                       32'hFFFF_4AFC, 0, 0, ONE, 24'h018000));
      directed_rays.push_back(make_ray(rrr_pkg::FUNC_REFRACT, ONE, 0, 0, 0, 0, ONE,
                                       24'h020000));
      directed_rays.push_back(make_ray(rrr_pkg::FUNC_REFLECT, ONE, 0, 0, 0, 0, ONE,
                                       24'hFFFFFF));
      directed_rays.push_back(make_ray(rrr_pkg::FUNC_REFLECT, PMAX, PMAX, PMAX, PMAX, PMAX,
                                       PMAX, 0));
      directed_rays.push_back(make_ray(rrr_pkg::FUNC_REFLECT, NMIN, NMIN, NMIN, NMIN, NMIN,
                                       NMIN, 0));
      directed_rays.push_back(make_ray(rrr_pkg::FUNC_REFLECT, PMAX, NMIN, PMAX, NMIN, PMAX,
                                       NMIN, 24'hFFFFFF));
      directed_rays.push_back(make_ray(rrr_pkg::FUNC_REFRACT, PMAX, PMAX, PMAX, PMAX, PMAX,
                                       PMAX, 24'hFFFFFF));
      directed_rays.push_back(make_ray(rrr_pkg::FUNC_REFRACT, NMIN, NMIN, NMIN, NMIN, NMIN,
                                       NMIN, 24'hFFFFFF));
      directed_rays.push_back(make_ray(rrr_pkg::FUNC_REFRACT, NMIN, PMAX, NMIN, PMAX, NMIN,
                                       PMAX, 24'h000001));
      directed_rays.push_back(make_ray(rrr_pkg::FUNC_REFRACT, 0, 0, 0, 0, 0, 0, 0));
      directed_rays.push_back(make_ray(rrr_pkg::FUNC_REFLECT, 0, 0, 0, 0, 0, 0, 0));
      directed_rays.push_back(make_ray(rrr_pkg::FUNC_REFRACT, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                       32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                       32'hFFFF_FFFF, 24'hFFFFFF));
      directed_rays.push_back(make_ray(rrr_pkg::FUNC_REFRACT, 32'h0003_0000, 0, 0, MONE,
                                       0, 0, 24'h010000));
      directed_rays.push_back(make_ray(rrr_pkg::FUNC_REFRACT, 32'h0000_4000, 0,
                                       32'hFFFF_C000, 0, 0, 32'h0004_0000, 24'h008000));
      directed_rays.push_back(make_ray(rrr_pkg::FUNC_REFLECT, 32'h5555_5555, 32'hAAAA_AAAA,
                                       32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                       32'hAAAA_AAAA, 24'hAAAAAA));
      directed_rays.push_back(make_ray(rrr_pkg::FUNC_REFRACT, 32'hAAAA_AAAA, 32'h5555_5555,
                                       32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                       32'h5555_5555, 24'h555555));
      foreach (directed_rays[i]) begin
         send_ray(directed_rays[i]);
      end

      // Random rays; partway through, the receiver holds off for a long stretch.
      for (int i = 0; i < NUM_RANDOM; i++) begin
         if (i == NUM_RANDOM / 2) begin
            hold_active = 1'b1;
         end
         send_ray(rand_ray());
      end
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (dir_board.expected_dirs.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (LATENCY + 10) @(posedge clock);

      $display("Sent %0d reflect and %0d refract rays, %0d responses checked.",
               reflect_count, refract_count, dir_board.checked);
      $display("Coverage included saturating extremes, zero vectors and a long output stall.");
      if (dir_board.mismatches == 0 && dir_board.expected_dirs.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatch count %0d, pending %0d", dir_board.mismatches,
                  dir_board.expected_dirs.size());
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
